FILE: hdl/block_bitmap_allocator_defines.svh
// ----------------------------------------------------------------------------
// Block bitmap allocator assertion macros
// Shared helpers for the concurrent checks of the allocator.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define BBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define BBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Widths, operation codes and shared types of the allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int StoreWords      = 128;
  localparam int WordBits        = 64;
  localparam int WordAddrW       = 7;
  localparam int BitSelW         = 6;
  localparam int IdxW            = 13;
  localparam int CntW            = 14;
  localparam int StoreBlocks     = 8192;
  localparam int DefBitmapBytes  = 1024;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FIND  = 2'd2,
    OP_COUNT = 2'd3
  } op_e;

  // Result of the shared word unit for one bitmap word.
  typedef struct packed {
    logic                avail_any;
    logic [BitSelW-1:0]  first_bit;
    logic [WordBits-1:0] new_word;
    logic                changed;
  } word_res_t;

endpackage

FILE: hdl/bba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int Width = 64,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/bba_word_unit.sv
// ----------------------------------------------------------------------------
// Bitmap word unit
// Finds the lowest free bit of one word and computes set and clear updates.
// ----------------------------------------------------------------------------
module bba_word_unit (
  input  logic [bba_pkg::WordBits-1:0] word_i,
  input  logic [bba_pkg::WordBits-1:0] mask_i,
  input  logic [bba_pkg::BitSelW-1:0]  bit_sel_i,
  input  logic                         set_i,
  output bba_pkg::word_res_t           res_o
);

  logic [bba_pkg::WordBits-1:0] avail;
  logic [bba_pkg::WordBits-1:0] lowest;
  logic [bba_pkg::WordBits-1:0] bit_mask;
  logic [bba_pkg::BitSelW-1:0]  pos;

  // Isolate the lowest free bit, then encode its one-hot position.
  assign avail    = ~word_i & mask_i;
  assign lowest   = avail & (~avail + bba_pkg::WordBits'(1));
  assign bit_mask = bba_pkg::WordBits'(1) << bit_sel_i;

  always_comb begin
    pos = '0;
    for (int b = 0; b < bba_pkg::WordBits; b++) begin
      if (lowest[b]) begin
        pos = pos | bba_pkg::BitSelW'(b);
      end
    end
  end

  always_comb begin
    res_o.avail_any = |avail;
    res_o.first_bit = pos;
    if (set_i) begin
      res_o.new_word = word_i | bit_mask;
      res_o.changed  = ~word_i[bit_sel_i];
    end else begin
      res_o.new_word = word_i & ~bit_mask;
      res_o.changed  = word_i[bit_sel_i];
    end
  end

endmodule

FILE: hdl/block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator
// First-fit allocator over a bitmap of disk blocks with running used count.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel, one operation per transfer: set a
// block used, clear it free, find the lowest free block, or read the counts.
// Each request gives exactly one result transfer on the m_axis channel with
// the found block, the none-free flag and the used and free totals.
// The bitmap lives in a 128 x 64 RAM; a sequencer drives one word unit that
// inspects one word per cycle. Set and clear read the word, write it back
// if it changes and load the result, and skip the read and write for an
// index beyond the block count; count only loads the result, and find reads
// words up to and including the first one with a free bit, at most
// ceil(blocks / 64), i.e. 128 words for 8192 blocks, then loads the result.
// The single RAM read port and the word-per-cycle scan bound a find's speed.
// A new request is taken only while the sequencer is idle; the result
// register lets the next request start while a result still waits.
// Reset clears the per-word valid bits and the used count, so every block
// reads free at once with no clearing pass. While the receiver stalls, the
// held result stays in place and the sequencer waits before loading another.
// ----------------------------------------------------------------------------
`include "block_bitmap_allocator_defines.svh"

module block_bitmap_allocator #(
  parameter int BitmapBytes = bba_pkg::DefBitmapBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] operation, [14:2] block_index, [15] zero
  input  logic [15:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [12:0] free_index, [26:13] used_count, [40:27] free_count, [47:41] zero
  output logic [47:0] m_axis_tdata_o,
  // [0] none_free
  output logic        m_axis_tuser_o
);

  localparam int WordBits    = bba_pkg::WordBits;
  localparam int WordAddrW   = bba_pkg::WordAddrW;
  localparam int BitSelW     = bba_pkg::BitSelW;
  localparam int IdxW        = bba_pkg::IdxW;
  localparam int CntW        = bba_pkg::CntW;
  localparam int TotalBlocks = (BitmapBytes * 8 > bba_pkg::StoreBlocks) ?
                               bba_pkg::StoreBlocks : BitmapBytes * 8;
  localparam int WordsUsed   = (TotalBlocks + WordBits - 1) / WordBits;
  localparam int TailBits    = TotalBlocks % WordBits;
  localparam logic [WordAddrW-1:0] LastWord = WordAddrW'(WordsUsed - 1);
  localparam logic [WordBits-1:0]  LastMask = (TailBits == 0) ? {WordBits{1'b1}} :
                                              ((WordBits'(1) << TailBits) - WordBits'(1));
  localparam logic [CntW-1:0]      TotalCnt = CntW'(TotalBlocks);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e                     state_q, state_d;
  bba_pkg::op_e               op_q, op_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic [WordAddrW-1:0]       ptr_q, ptr_d;
  logic [WordAddrW-1:0]       rd_addr_q, rd_addr_d;
  logic [bba_pkg::StoreWords-1:0] row_valid_q;
  logic [CntW-1:0]            used_q, used_d;
  logic [IdxW-1:0]            found_q, found_d;
  logic                       none_q, none_d;
  logic                       out_valid_q, out_valid_d;
  logic [IdxW-1:0]            out_index_q, out_index_d;
  logic                       out_none_q, out_none_d;
  logic [CntW-1:0]            out_used_q, out_used_d;
  logic [CntW-1:0]            out_free_q, out_free_d;

  logic                       ram_we;
  logic [WordBits-1:0]        ram_rdata;
  logic [WordBits-1:0]        word;
  logic [WordBits-1:0]        scan_mask;
  bba_pkg::word_res_t         res;
  logic [IdxW-1:0]            in_idx;
  logic                       in_range;
  logic                       out_free_slot;

  assign in_idx        = s_axis_tdata_i[14:2];
  assign in_range      = {1'b0, in_idx} < TotalCnt;
  assign out_free_slot = !out_valid_q || m_axis_tready_i;

  // Rows never written since reset read as all free.
  assign word      = row_valid_q[rd_addr_q] ? ram_rdata : '0;
  assign scan_mask = (ptr_q == LastWord) ? LastMask : {WordBits{1'b1}};

  bba_ram #(
    .Width (WordBits),
    .Depth (bba_pkg::StoreWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[IdxW-1:BitSelW]),
    .wdata_i (res.new_word),
    .raddr_i (rd_addr_d),
    .rdata_o (ram_rdata)
  );

  bba_word_unit u_word (
    .word_i    (word),
    .mask_i    (scan_mask),
    .bit_sel_i (idx_q[BitSelW-1:0]),
    .set_i     (op_q == bba_pkg::OP_SET),
    .res_o     (res)
  );

  always_comb begin
    state_d         = state_q;
    op_d            = op_q;
    idx_d           = idx_q;
    ptr_d           = ptr_q;
    rd_addr_d       = rd_addr_q;
    used_d          = used_q;
    found_d         = found_q;
    none_d          = none_q;
    ram_we          = 1'b0;
    s_axis_tready_o = 1'b0;
    out_valid_d     = out_valid_q && !m_axis_tready_i;
    out_index_d     = out_index_q;
    out_none_d      = out_none_q;
    out_used_d      = out_used_q;
    out_free_d      = out_free_q;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          op_d    = bba_pkg::op_e'(s_axis_tdata_i[1:0]);
          idx_d   = in_idx;
          found_d = '0;
          none_d  = 1'b0;
          unique case (bba_pkg::op_e'(s_axis_tdata_i[1:0]))
            bba_pkg::OP_SET, bba_pkg::OP_CLEAR: begin
              if (in_range) begin
                rd_addr_d = in_idx[IdxW-1:BitSelW];
                state_d   = S_RD;
              end else begin
                state_d = S_DONE;
              end
            end
            bba_pkg::OP_FIND: begin
              rd_addr_d = '0;
              ptr_d     = '0;
              state_d   = S_SCAN;
            end
            bba_pkg::OP_COUNT: begin
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_RD: begin
        if (res.changed) begin
          ram_we = 1'b1;
          used_d = (op_q == bba_pkg::OP_SET) ? used_q + CntW'(1) : used_q - CntW'(1);
        end
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (res.avail_any) begin
          found_d = {ptr_q, res.first_bit};
          state_d = S_DONE;
        end else if (ptr_q == LastWord) begin
          none_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          ptr_d     = ptr_q + WordAddrW'(1);
          rd_addr_d = ptr_q + WordAddrW'(1);
        end
      end
      S_DONE: begin
        if (out_free_slot) begin
          out_valid_d = 1'b1;
          out_index_d = found_q;
          out_none_d  = none_q;
          out_used_d  = used_q;
          out_free_d  = TotalCnt - used_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        row_valid_q[idx_q[IdxW-1:BitSelW]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    idx_q       <= idx_d;
    ptr_q       <= ptr_d;
    rd_addr_q   <= rd_addr_d;
    found_q     <= found_d;
    none_q      <= none_d;
    out_index_q <= out_index_d;
    out_none_q  <= out_none_d;
    out_used_q  <= out_used_d;
    out_free_q  <= out_free_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_free_q, out_used_q, out_index_q};
  assign m_axis_tuser_o  = out_none_q;

  `BBA_ASSERT(a_used_bound, used_q <= TotalCnt, "used count exceeds block count")
  `BBA_ASSERT_IMP(a_used_step, used_q != $past(used_q), $past(state_q) == S_RD,
                  "used count changed outside a set or clear update")
  `BBA_ASSERT_IMP(a_result_src, $rose(out_valid_q), $past(state_q) == S_DONE,
                  "result appeared without a finished request")
  `BBA_ASSERT_IMP(a_scan_range, state_q == S_SCAN, ptr_q <= LastWord,
                  "scan pointer ran past the last bitmap word")

endmodule
